>>> design/indexed_doubly_linked_list_assert.svh
// assertion macros for the linked list block
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication
`define IDLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/idll_pkg.sv
package idll_pkg;

  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_INS_AFTER  = 3'd1;
  localparam logic [2:0] CMD_INS_BEFORE = 3'd2;
  localparam logic [2:0] CMD_ERASE      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_SENTINEL = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         node_index;
    logic signed [31:0] node_value;
    logic [7:0]         load_next;
    logic [7:0]         load_prev;
  } idll_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [7:0]         new_node;
    logic [7:0]         out_next;
    logic [7:0]         out_prev;
    logic [1:0]         status;
  } idll_out_t;

  typedef struct packed {
    logic        re;
    logic [7:0]  raddr;
    logic        v_we;
    logic [7:0]  v_waddr;
    logic [31:0] v_wdata;
    logic        n_we;
    logic [7:0]  n_waddr;
    logic [7:0]  n_wdata;
    logic        p_we;
    logic [7:0]  p_waddr;
    logic [7:0]  p_wdata;
  } idll_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  nxt;
    logic [7:0]  prv;
  } idll_rsp_t;

endpackage

>>> design/idll_ram.sv
module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/idll_store.sv
module idll_store #(
  parameter int NODE_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  idll_pkg::idll_req_t req,
  output idll_pkg::idll_rsp_t rsp
);
  import idll_pkg::*;

  localparam int CAP = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int AW  = $clog2(CAP);

  logic [AW-1:0] mod_tab [256];
  logic [AW-1:0] ra;
  logic [AW-1:0] va;
  logic [AW-1:0] na;
  logic [AW-1:0] pa;
  logic [31:0]   v_rd;
  logic [7:0]    n_rd;
  logic [7:0]    p_rd;
  logic          n0_wr_r;
  logic          p0_wr_r;
  logic          nmask_r;
  logic          pmask_r;

  // index reduction modulo the node count
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % NODE_COUNT);
  end

  assign ra = mod_tab[req.raddr];
  assign va = mod_tab[req.v_waddr];
  assign na = mod_tab[req.n_waddr];
  assign pa = mod_tab[req.p_waddr];

  idll_ram #(.WIDTH(32), .DEPTH(CAP)) u_value (
    .clk(clk), .we(req.v_we), .waddr(va), .wdata(req.v_wdata),
    .re(req.re), .raddr(ra), .rdata(v_rd)
  );

  idll_ram #(.WIDTH(8), .DEPTH(CAP)) u_next (
    .clk(clk), .we(req.n_we), .waddr(na), .wdata(req.n_wdata),
    .re(req.re), .raddr(ra), .rdata(n_rd)
  );

  idll_ram #(.WIDTH(8), .DEPTH(CAP)) u_prev (
    .clk(clk), .we(req.p_we), .waddr(pa), .wdata(req.p_wdata),
    .re(req.re), .raddr(ra), .rdata(p_rd)
  );

  // sentinel links read as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_wr_r <= 1'b0;
      p0_wr_r <= 1'b0;
      nmask_r <= 1'b1;
      pmask_r <= 1'b1;
    end else begin
      if (req.n_we && na == '0) begin
        n0_wr_r <= 1'b1;
      end
      if (req.p_we && pa == '0) begin
        p0_wr_r <= 1'b1;
      end
      if (req.re) begin
        nmask_r <= (ra == '0) && !n0_wr_r;
        pmask_r <= (ra == '0) && !p0_wr_r;
      end
    end
  end

  assign rsp.value = v_rd;
  assign rsp.nxt   = nmask_r ? 8'd0 : n_rd;
  assign rsp.prv   = pmask_r ? 8'd0 : p_rd;

endmodule

>>> design/indexed_doubly_linked_list.sv
// Doubly linked list over three node memories (value, next, prev), node 0 the sentinel.
// Each command runs the accept cycle, which issues the node read, then the write-back
// states WR1 and WR2, which update the link memories (an insert writes two entries in
// each). busy is high in WR1 and WR2 after start is taken; the result appears with
// out_strobe for one cycle after that, and a new command may start in that same
// cycle, so commands never overlap. The receiver cannot stall: out_word is valid
// only while out_strobe is high. cfg_we sets the preloaded count and restarts the
// node allocator just after it; write it only while the block is idle.
module indexed_doubly_linked_list #(
  parameter int NODE_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  idll_pkg::idll_in_t  in_word,
  output logic                out_strobe,
  output idll_pkg::idll_out_t out_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import idll_pkg::*;

  localparam int CAP = (NODE_COUNT < 256) ? NODE_COUNT : 256;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR1  = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  logic [1:0] state_r, state_nxt;
  idll_in_t   in_r;
  logic [7:0] head_r, head_nxt;
  logic [7:0] tail_r, tail_nxt;
  logic [8:0] alloc_r, alloc_nxt;
  idll_out_t  out_r, out_nxt;
  logic       out_strobe_r, out_strobe_nxt;
  idll_req_t  req;
  idll_rsp_t  rsp;
  logic       accept;
  logic       full;
  logic       ins_ok;
  logic [7:0] nn;

  idll_store #(.NODE_COUNT(NODE_COUNT)) u_store (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (alloc_r >= 9'(CAP));
  assign nn     = alloc_r[7:0];
  assign ins_ok = (in_r.cmd == CMD_INS_AFTER || in_r.cmd == CMD_INS_BEFORE) && !full;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    alloc_nxt      = alloc_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    req            = '0;
    req.re         = accept;
    req.raddr      = in_word.node_index;

    if (cfg_we) begin
      alloc_nxt = {1'b0, cfg_wdata} + 9'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WR1;
        end
      end
      ST_WR1: begin
        state_nxt = ST_WR2;
        case (in_r.cmd)
          CMD_LOAD: begin
            req.v_we    = 1'b1;
            req.v_waddr = in_r.node_index;
            req.v_wdata = in_r.node_value;
            req.n_we    = 1'b1;
            req.n_waddr = in_r.node_index;
            req.n_wdata = in_r.load_next;
            req.p_we    = 1'b1;
            req.p_waddr = in_r.node_index;
            req.p_wdata = in_r.load_prev;
            if (in_r.node_index == 8'd0) begin
              head_nxt = in_r.load_next;
              tail_nxt = in_r.load_prev;
            end
          end
          CMD_INS_AFTER: begin
            if (ins_ok) begin
              req.v_we    = 1'b1;
              req.v_waddr = nn;
              req.v_wdata = in_r.node_value;
              req.n_we    = 1'b1;
              req.n_waddr = nn;
              req.n_wdata = rsp.nxt;
              req.p_we    = 1'b1;
              req.p_waddr = nn;
              req.p_wdata = in_r.node_index;
              if (in_r.node_index == 8'd0) begin
                head_nxt = nn;
              end
              if (in_r.node_index == tail_r) begin
                tail_nxt = nn;
              end
            end
          end
          CMD_INS_BEFORE: begin
            if (ins_ok) begin
              req.v_we    = 1'b1;
              req.v_waddr = nn;
              req.v_wdata = in_r.node_value;
              req.p_we    = 1'b1;
              req.p_waddr = nn;
              req.p_wdata = rsp.prv;
              req.n_we    = 1'b1;
              req.n_waddr = nn;
              req.n_wdata = in_r.node_index;
              if (in_r.node_index == 8'd0) begin
                tail_nxt = nn;
              end
              if (in_r.node_index == head_r) begin
                head_nxt = nn;
              end
            end
          end
          CMD_ERASE: begin
            if (in_r.node_index != 8'd0) begin
              req.n_we    = 1'b1;
              req.n_waddr = rsp.prv;
              req.n_wdata = rsp.nxt;
              req.p_we    = 1'b1;
              req.p_waddr = rsp.nxt;
              req.p_wdata = rsp.prv;
              if (in_r.node_index == tail_r) begin
                tail_nxt = rsp.prv;
              end
              if (in_r.node_index == head_r) begin
                head_nxt = rsp.nxt;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_WR2: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
        out_nxt        = '0;
        if (ins_ok) begin
          alloc_nxt = alloc_r + 9'd1;
          if (in_r.cmd == CMD_INS_AFTER) begin
            req.n_we    = 1'b1;
            req.n_waddr = in_r.node_index;
            req.n_wdata = nn;
            req.p_we    = 1'b1;
            req.p_waddr = rsp.nxt;
            req.p_wdata = nn;
          end else begin
            req.n_we    = 1'b1;
            req.n_waddr = rsp.prv;
            req.n_wdata = nn;
            req.p_we    = 1'b1;
            req.p_waddr = in_r.node_index;
            req.p_wdata = nn;
          end
        end
        case (in_r.cmd) inside
          CMD_INS_AFTER, CMD_INS_BEFORE: begin
            if (full) begin
              out_nxt.status = STAT_FULL;
            end else begin
              out_nxt.new_node = nn;
            end
          end
          CMD_ERASE: begin
            if (in_r.node_index == 8'd0) begin
              out_nxt.status = STAT_SENTINEL;
            end else begin
              out_nxt.out_value = rsp.value;
            end
          end
          CMD_READ: begin
            out_nxt.out_value = rsp.value;
            out_nxt.out_next  = rsp.nxt;
            out_nxt.out_prev  = rsp.prv;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= 8'd0;
      tail_r       <= 8'd0;
      alloc_r      <= 9'd1;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      alloc_r      <= alloc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

endmodule

>>> design/idll_chk.sv
`include "indexed_doubly_linked_list_assert.svh"

module idll_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input idll_pkg::idll_out_t out_word
);
  import idll_pkg::*;

  `IDLL_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy not raised after start")
  `IDLL_ASSERT_NOW(a_word_latency, start && !busy, ##3 out_strobe, "result word not on time")
  `IDLL_ASSERT_NOW(a_idle_on_strobe, out_strobe, !busy, "busy during result word")
  `IDLL_ASSERT_NEXT(a_single_strobe, out_strobe, !out_strobe, "result word repeated")
  `IDLL_ASSERT_NOW(a_status_code, out_strobe, out_word.status <= STAT_SENTINEL, "bad status")

endmodule

bind indexed_doubly_linked_list idll_chk u_idll_chk (.*);
